@@ hdl/sa_pkg.sv @@
// Shared types, codes and default sizes for the slot allocator.
package sa_pkg;

  localparam int SLOT_BITS     = 10;
  localparam int ELEM_BITS     = 32;
  localparam int CAPACITY_DEF  = 1024;
  localparam int DATA_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Control of the item held in the resolve stage.
  typedef struct packed {
    logic valid;
    op_t  op;
    logic has_data;
    logic pop;
    logic full;
    logic range_err;
  } issue_ctl_t;

endpackage

@@ hdl/sa_if.sv @@
// Request and response channel interfaces of the slot allocator.
interface sa_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic [sa_pkg::SLOT_BITS-1:0] slot_index;
  logic                        has_data;
  logic [sa_pkg::ELEM_BITS-1:0] elem_data;

  modport source (output valid, opcode, slot_index, has_data, elem_data, input ready);
  modport sink   (input valid, opcode, slot_index, has_data, elem_data, output ready);
endinterface

interface sa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sa_pkg::SLOT_BITS-1:0] slot_out;
  logic [sa_pkg::ELEM_BITS-1:0] data_out;
  logic [1:0]                  status;

  modport source (output valid, slot_out, data_out, status, input ready);
  modport sink   (input valid, slot_out, data_out, status, output ready);
endinterface

@@ hdl/slot_allocator_free_stack.sv @@
// Slot allocator top level: free stack and slot store memories, resolve stage, output register.
// Fixed pool of CAPACITY slots. An add reuses the most recently removed slot, or else the
// next never-used one; a remove pushes a slot below the cursor back on the free stack unless
// the stack is full; a get returns a slot's data. The block takes one request per cycle. The
// request transfer edge launches the free stack and slot store reads (synchronous RAMs), and
// the resolve stage then resolves the slot; as it advances it writes the store and loads the
// output register, which holds the response until it transfers. A stalled response stalls
// requests only once the resolve stage is also occupied. No clearing pass is needed after
// reset; slot data read before any add wrote them is undefined.
module slot_allocator_free_stack #(
  parameter int CAPACITY  = sa_pkg::CAPACITY_DEF,
  parameter int DATA_BITS = sa_pkg::DATA_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  sa_req_if.sink  req,
  sa_rsp_if.source rsp
);
  import sa_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic                 accept;
  logic                 b_adv;
  logic                 fs_re, fs_we, st_re, st_we;
  logic [AW-1:0]        fs_raddr, fs_waddr, fs_wdata, fs_rdata;
  logic [AW-1:0]        st_raddr;
  logic [DATA_BITS-1:0] st_rdata;
  issue_ctl_t           b_ctl;
  logic [SLOT_BITS-1:0] b_slot;
  logic [AW-1:0]        b_fresh;
  logic [DATA_BITS-1:0] b_data;
  logic [AW-1:0]        got;
  logic                 fwd_hit;
  logic [DATA_BITS-1:0] fwd_data;
  logic [SLOT_BITS-1:0] slot_res;
  logic [ELEM_BITS-1:0] data_res;
  status_t              status_res;

  assign b_adv      = b_ctl.valid && (!rsp.valid || rsp.ready);
  assign req.ready  = !b_ctl.valid || b_adv;
  assign accept     = req.valid && req.ready;

  sa_issue #(
    .CAPACITY  (CAPACITY),
    .DATA_BITS (DATA_BITS)
  ) u_issue (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .b_adv      (b_adv),
    .opcode     (req.opcode),
    .slot_index (req.slot_index),
    .has_data   (req.has_data),
    .elem_data  (req.elem_data),
    .fs_re      (fs_re),
    .fs_raddr   (fs_raddr),
    .fs_we      (fs_we),
    .fs_waddr   (fs_waddr),
    .fs_wdata   (fs_wdata),
    .st_re      (st_re),
    .st_raddr   (st_raddr),
    .b_ctl      (b_ctl),
    .b_slot     (b_slot),
    .b_fresh    (b_fresh),
    .b_data     (b_data)
  );

  sa_ram #(
    .WIDTH (AW),
    .DEPTH (CAPACITY)
  ) u_free_stack (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .re    (fs_re),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  assign got   = b_ctl.pop ? fs_rdata : b_fresh;
  assign st_we = b_adv && (b_ctl.op == OP_ADD) && !b_ctl.full && b_ctl.has_data;

  sa_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (CAPACITY)
  ) u_slot_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (got),
    .wdata (b_data),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // A get that reads the slot an add writes in the same cycle takes the new data.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (accept) begin
      fwd_hit <= st_re && st_we && (st_raddr == got);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data <= b_data;
    end
  end

  always_comb begin
    slot_res   = b_slot;
    data_res   = '0;
    status_res = ST_OK;
    case (b_ctl.op)
      OP_ADD: begin
        if (b_ctl.full) begin
          slot_res   = '0;
          status_res = ST_FULL;
        end else begin
          slot_res = SLOT_BITS'(got);
        end
      end
      OP_REMOVE: begin
        if (b_ctl.range_err) begin
          status_res = ST_RANGE;
        end
      end
      OP_GET: begin
        if (b_ctl.range_err) begin
          status_res = ST_RANGE;
        end else begin
          data_res = ELEM_BITS'(fwd_hit ? fwd_data : st_rdata);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (b_adv) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      rsp.slot_out <= slot_res;
      rsp.data_out <= data_res;
      rsp.status   <= status_res;
    end
  end

endmodule

@@ hdl/sa_ram.sv @@
// Simple dual-port RAM with one write port and a registered read port.
module sa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/sa_issue.sv @@
// Issue stage: free stack and cursor bookkeeping, memory requests, resolve-stage register.
module sa_issue #(
  parameter int CAPACITY  = sa_pkg::CAPACITY_DEF,
  parameter int DATA_BITS = sa_pkg::DATA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          b_adv,
  input  logic [1:0]                    opcode,
  input  logic [sa_pkg::SLOT_BITS-1:0]  slot_index,
  input  logic                          has_data,
  input  logic [sa_pkg::ELEM_BITS-1:0]  elem_data,
  output logic                          fs_re,
  output logic [$clog2(CAPACITY)-1:0]   fs_raddr,
  output logic                          fs_we,
  output logic [$clog2(CAPACITY)-1:0]   fs_waddr,
  output logic [$clog2(CAPACITY)-1:0]   fs_wdata,
  output logic                          st_re,
  output logic [$clog2(CAPACITY)-1:0]   st_raddr,
  output sa_pkg::issue_ctl_t            b_ctl,
  output logic [sa_pkg::SLOT_BITS-1:0]  b_slot,
  output logic [$clog2(CAPACITY)-1:0]   b_fresh,
  output logic [DATA_BITS-1:0]          b_data
);
  import sa_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > SLOT_BITS) ? CW : SLOT_BITS;

  logic [CW-1:0] free_count, free_count_next;
  logic [CW-1:0] next_fresh, next_fresh_next;
  logic [IW-1:0] idx_w;
  logic          in_range;
  logic          stack_empty;
  logic          stack_full;
  logic          fresh_left;
  op_t           op;
  issue_ctl_t    ctl;

  assign op          = op_t'(opcode);
  assign idx_w       = IW'(slot_index);
  assign in_range    = idx_w < IW'(next_fresh);
  assign stack_empty = (free_count == '0);
  assign stack_full  = (free_count == CW'(CAPACITY));
  assign fresh_left  = (next_fresh != CW'(CAPACITY));

  always_comb begin
    free_count_next = free_count;
    next_fresh_next = next_fresh;
    fs_re           = 1'b0;
    fs_raddr        = AW'(free_count - CW'(1));
    fs_we           = 1'b0;
    fs_waddr        = free_count[AW-1:0];
    fs_wdata        = idx_w[AW-1:0];
    st_re           = 1'b0;
    st_raddr        = idx_w[AW-1:0];
    ctl             = '0;
    ctl.valid       = 1'b1;
    ctl.op          = op;
    ctl.has_data    = has_data;
    case (op)
      OP_ADD: begin
        if (!stack_empty) begin
          // Reuse the most recently freed slot.
          ctl.pop         = 1'b1;
          fs_re           = accept;
          free_count_next = free_count - CW'(1);
        end else if (fresh_left) begin
          next_fresh_next = next_fresh + CW'(1);
        end else begin
          ctl.full = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (in_range) begin
          // Drop the push when the stack is already full.
          if (!stack_full) begin
            fs_we           = accept;
            free_count_next = free_count + CW'(1);
          end
        end else begin
          ctl.range_err = 1'b1;
        end
      end
      OP_GET: begin
        if (in_range) begin
          st_re = accept;
        end else begin
          ctl.range_err = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
      next_fresh <= '0;
      b_ctl      <= '0;
    end else if (accept) begin
      free_count <= free_count_next;
      next_fresh <= next_fresh_next;
      b_ctl      <= ctl;
    end else if (b_adv) begin
      b_ctl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_slot  <= slot_index;
      b_fresh <= next_fresh[AW-1:0];
      b_data  <= DATA_BITS'(elem_data);
    end
  end

endmodule

@@ tb/slot_allocator_free_stack_checker.sv @@
// Checker for the slot allocator: predicts each response from accepted requests and compares.
module slot_allocator_free_stack_checker (
  input  logic clk,
  input  logic rst,
  sa_req_if    req,
  sa_rsp_if    rsp,
  output int   mismatches,
  output int   outstanding
);
  import sa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SLOT_BITS-1:0] slot;
    logic [ELEM_BITS-1:0] data;
    status_t              status;
  } alloc_rsp_t;

  logic [ELEM_BITS-1:0] slot_data [CAPACITY_DEF];
  logic [SLOT_BITS-1:0] freed_slots [CAPACITY_DEF];
  int                   freed_depth;
  int                   fresh_cursor;
  int                   err_total;
  alloc_rsp_t           pending_rsp[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    err_total   = 0;
  end

  function automatic alloc_rsp_t allocate_or_access(op_t op, logic [SLOT_BITS-1:0] idx,
                                                    logic has, logic [ELEM_BITS-1:0] word);
    alloc_rsp_t r;
    r.slot   = idx;
    r.data   = '0;
    r.status = ST_OK;
    case (op)
      OP_ADD: begin
        // reuse the most recently freed slot before touching the cursor
        if (freed_depth > 0) begin
          freed_depth--;
          r.slot = freed_slots[freed_depth];
        end else if (fresh_cursor < CAPACITY_DEF) begin
          r.slot = fresh_cursor[SLOT_BITS-1:0];
          fresh_cursor++;
        end else begin
          r.slot   = '0;
          r.status = ST_FULL;
        end
        if (r.status == ST_OK && has) slot_data[r.slot] = word;
      end
      OP_REMOVE: begin
        if (idx < fresh_cursor) begin
          // drop the push once the stack is full
          if (freed_depth < CAPACITY_DEF) begin
            freed_slots[freed_depth] = idx;
            freed_depth++;
          end
        end else begin
          r.status = ST_RANGE;
        end
      end
      OP_GET: begin
        if (idx < fresh_cursor) r.data = slot_data[idx];
        else r.status = ST_RANGE;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_error(string msg);
    err_total++;
    if (err_total <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    alloc_rsp_t got;
    alloc_rsp_t want;
    if (rst) begin
      freed_depth  = 0;
      fresh_cursor = 0;
      pending_rsp.delete();
    end else begin
      if (req.valid && req.ready)
        pending_rsp.push_back(allocate_or_access(op_t'(req.opcode), req.slot_index,
                                                 req.has_data, req.elem_data));
      if (rsp.valid && rsp.ready) begin
        got.slot   = rsp.slot_out;
        got.data   = rsp.data_out;
        got.status = status_t'(rsp.status);
        if (pending_rsp.size() == 0) begin
          flag_error($sformatf("unexpected response slot=%0d data=%h status=%0d",
                               got.slot, got.data, got.status));
        end else begin
          want = pending_rsp.pop_front();
          if (got.slot !== want.slot || got.data !== want.data || got.status !== want.status)
            flag_error($sformatf({"response mismatch: slot exp %0d got %0d, ",
                                  "data exp %h got %h, status exp %0d got %0d"},
                                 want.slot, got.slot, want.data, got.data,
                                 want.status, got.status));
        end
      end
    end
    mismatches  <= err_total;
    outstanding <= pending_rsp.size();
  end

endmodule

@@ tb/slot_allocator_free_stack_tb.sv @@
// Top of the slot allocator testbench: clock, reset, request stimulus, response stalls, verdict.
module slot_allocator_free_stack_tb;
  import sa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [SLOT_BITS-1:0] TOP_SLOT = SLOT_BITS'(CAPACITY_DEF - 1);

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  bit   hold_req;
  int   burst_left;

  // pool view kept by the stimulus so that no get reads a never-written slot
  int                   pool_cursor;
  logic [SLOT_BITS-1:0] pool_freed[$];
  bit                   pool_written [CAPACITY_DEF];
  logic [SLOT_BITS-1:0] written_slots[$];

  sa_req_if req_ch ();
  sa_rsp_if rsp_ch ();

  slot_allocator_free_stack i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  slot_allocator_free_stack_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // idle watchdog: cycles with no transfer on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // response side: stall patterns that change at random, plus one long hold
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int step;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    step      = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        step++;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 99) < 70);
          2: rsp_ch.ready <= ((step % 5) >= 2);
          default: rsp_ch.ready <= ($urandom_range(0, 99) < 25);
        endcase
      end
    end
  end

  function automatic logic [ELEM_BITS-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SLOT_BITS-1:0] rand_slot();
    return SLOT_BITS'($urandom_range(0, CAPACITY_DEF - 1));
  endfunction

  function automatic logic rand_flag();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [SLOT_BITS-1:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75 && pool_cursor > 0) return SLOT_BITS'($urandom_range(0, pool_cursor - 1));
    if (r < 88) return rand_slot();
    if (r < 93) return TOP_SLOT;
    return (pool_cursor >= CAPACITY_DEF) ? TOP_SLOT : SLOT_BITS'(pool_cursor);
  endfunction

  function automatic void track_pool(op_t op, logic [SLOT_BITS-1:0] idx, logic has);
    logic [SLOT_BITS-1:0] slot;
    bit                   ok;
    ok = 1'b1;
    if (op == OP_ADD) begin
      if (pool_freed.size() > 0) slot = pool_freed.pop_back();
      else if (pool_cursor < CAPACITY_DEF) begin
        slot = SLOT_BITS'(pool_cursor);
        pool_cursor++;
      end else ok = 1'b0;
      if (ok && has && !pool_written[slot]) begin
        pool_written[slot] = 1'b1;
        written_slots.push_back(slot);
      end
    end else if (op == OP_REMOVE) begin
      if (idx < pool_cursor && pool_freed.size() < CAPACITY_DEF) pool_freed.push_back(idx);
    end
  endfunction

  task automatic issue(op_t op, logic [SLOT_BITS-1:0] idx, logic has, logic [ELEM_BITS-1:0] word);
    int gap;
    // redirect a get of a never-written slot
    if (op == OP_GET && idx < pool_cursor && !pool_written[idx]) begin
      if (written_slots.size() > 0)
        idx = written_slots[$urandom_range(0, written_slots.size() - 1)];
      else if (pool_cursor < CAPACITY_DEF)
        idx = SLOT_BITS'($urandom_range(pool_cursor, CAPACITY_DEF - 1));
      else
        op = OP_NOP;
    end
    track_pool(op, idx, has);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 30);
    end
    burst_left--;
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.slot_index <= idx;
    req_ch.has_data   <= has;
    req_ch.elem_data  <= word;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic run_mixed(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        issue(OP_ADD, rand_slot(), $urandom_range(0, 9) < 8, rand_word());
      else if (r < 70)
        issue(OP_REMOVE, pick_index(), rand_flag(), rand_word());
      else if (r < 95)
        issue(OP_GET, pick_index(), rand_flag(), rand_word());
      else
        issue(OP_NOP, rand_slot(), rand_flag(), rand_word());
    end
  endtask

  initial begin
    rst        = 1'b1;
    hold_req   = 1'b0;
    burst_left = 0;
    pool_cursor = 0;
    req_ch.valid      <= 1'b0;
    req_ch.opcode     <= OP_NOP;
    req_ch.slot_index <= '0;
    req_ch.has_data   <= 1'b0;
    req_ch.elem_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty pool: every index is out of range
    issue(OP_GET, '0, 1'b0, '0);
    issue(OP_REMOVE, '0, 1'b0, '0);
    issue(OP_REMOVE, TOP_SLOT, 1'b1, '1);
    issue(OP_NOP, TOP_SLOT, 1'b1, '1);
    // fresh slots from the cursor, the last one left unwritten
    issue(OP_ADD, TOP_SLOT, 1'b1, '1);
    issue(OP_ADD, '0, 1'b1, '0);
    issue(OP_ADD, '0, 1'b0, 32'h1357_9bdf);
    issue(OP_GET, '0, 1'b0, '0);
    issue(OP_GET, SLOT_BITS'(1), 1'b1, '1);
    issue(OP_GET, SLOT_BITS'(3), 1'b0, '0);
    issue(OP_REMOVE, SLOT_BITS'(3), 1'b0, '0);
    // LIFO reuse and stale contents
    issue(OP_REMOVE, SLOT_BITS'(1), 1'b0, '0);
    issue(OP_REMOVE, '0, 1'b0, '0);
    issue(OP_ADD, '0, 1'b1, 32'ha5a5_5a5a);
    issue(OP_ADD, '0, 1'b0, 32'hffff_0000);
    issue(OP_GET, SLOT_BITS'(1), 1'b0, '0);
    issue(OP_GET, '0, 1'b0, '0);
    // double free hands out the same slot twice
    issue(OP_REMOVE, '0, 1'b0, '0);
    issue(OP_REMOVE, '0, 1'b1, '1);
    issue(OP_ADD, '0, 1'b1, 32'h0000_1234);
    issue(OP_ADD, '0, 1'b1, 32'h8765_0000);
    issue(OP_GET, '0, 1'b0, '0);
    issue(OP_NOP, '0, 1'b0, 32'hdead_beef);
    wait_drained();

    // long response hold while requests keep coming
    hold_req = 1'b1;
    run_mixed(150);
    wait_drained();

    // fill the pool until adds report full
    while (!(pool_cursor == CAPACITY_DEF && pool_freed.size() == 0)) begin
      if ($urandom_range(0, 99) < 97)
        issue(OP_ADD, rand_slot(), $urandom_range(0, 9) < 8, rand_word());
      else
        issue(OP_GET, pick_index(), 1'b0, rand_word());
    end
    repeat (4) issue(OP_ADD, rand_slot(), 1'b1, rand_word());
    issue(OP_GET, pick_index(), 1'b0, '0);
    wait_drained();

    // free until the stack overflows with double frees
    while (pool_freed.size() < CAPACITY_DEF) begin
      if ($urandom_range(0, 99) < 97)
        issue(OP_REMOVE, rand_slot(), rand_flag(), rand_word());
      else
        issue(OP_GET, pick_index(), 1'b0, rand_word());
    end
    repeat (4) issue(OP_REMOVE, rand_slot(), 1'b0, rand_word());
    repeat (3) issue(OP_ADD, '0, 1'b1, rand_word());
    issue(OP_GET, pick_index(), 1'b0, '0);

    run_mixed(60);
    wait_drained();
    repeat (8) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
